// ===== src/clv_pkg.sv =====
// Shared types, error codes and constants of the command list validator.
package clv_pkg;

   localparam int WORDS_PER_CMD      = 6;
   localparam int DEF_MAX_COMMANDS   = 256;
   localparam int DEF_FUNCTION_COUNT = 16;

   // Reciprocal of six, exact for word indexes below 2**17.
   localparam int DIV6_SHIFT = 18;
   localparam int DIV6_MUL   = 43691;
   localparam int DIV6_MUL_W = 16;

   localparam logic [4:0] ERR_NONE      = 5'd0;
   localparam logic [4:0] ERR_FUNC      = 5'd1;
   localparam logic [4:0] ERR_RET       = 5'd2;
   localparam logic [4:0] ERR_ARG1_KIND = 5'd3;
   localparam logic [4:0] ERR_ARG2_KIND = 5'd4;
   localparam logic [4:0] ERR_ARG1_BASE = 5'd4;
   localparam logic [4:0] ERR_ARG2_BASE = 5'd10;
   localparam logic [4:0] ERR_OVERFLOW  = 5'd17;

   localparam logic [2:0] ARG_OK    = 3'd0;
   localparam logic [2:0] ARG_RANGE = 3'd1;
   localparam logic [2:0] ARG_ALIGN = 3'd2;
   localparam logic [2:0] ARG_SELF  = 3'd3;
   localparam logic [2:0] ARG_AHEAD = 3'd4;
   localparam logic [2:0] ARG_TYPE  = 3'd5;
   localparam logic [2:0] ARG_CONST = 3'd6;

   localparam logic [1:0] RK_FLOAT   = 2'd0;
   localparam logic [1:0] RK_COMPLEX = 2'd1;
   localparam logic [1:0] RK_OTHER   = 2'd2;

   localparam int CSR_FLOAT_COUNT   = 0;
   localparam int CSR_COMPLEX_COUNT = 1;

   typedef struct packed {
      logic [31:0] function_code;
      logic [31:0] return_kind;
      logic [31:0] first_arg_kind;
      logic [31:0] first_arg_ref;
      logic [31:0] second_arg_kind;
      logic [31:0] second_arg_ref;
      logic        end_of_list;
   } cmd_type;

   typedef struct packed {
      logic [4:0] error_code;
      logic [7:0] failing_command;
   } result_type;

endpackage

// ===== src/command_list_validator_core.sv =====
// Command list validator: command store, checking pipeline and register port.
//
// Loading takes one command per cycle; busy stays low while a list is loaded.
// After the flagged command of a list, busy stays high while the check pipeline reads
// one stored command per cycle through four stages (row read, range and reciprocal
// multiply, return-type read, evaluation); the result strobe comes in the cycle busy
// drops, sooner when an early command fails.
// A list that overflowed gives its result in the cycle after the flagged transfer.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Synchronous reset clears the state, counter and valid registers, the command count
// and the overflow flag; the command store needs no clearing pass.
module command_list_validator_core
   import clv_pkg::*;
#(
   parameter int MAX_COMMANDS   = DEF_MAX_COMMANDS,
   parameter int FUNCTION_COUNT = DEF_FUNCTION_COUNT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  cmd_type    req_command,
   output logic       rsp_strobe,
   output result_type rsp_result,
   input  logic       psel,
   input  logic       penable,
   input  logic       pwrite,
   input  logic [2:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic       pready
);

   localparam int ADDR_W = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
   localparam int CNT_W  = $clog2(MAX_COMMANDS + 1);
   localparam int LEN_W  = $clog2(MAX_COMMANDS * WORDS_PER_CMD + 1);
   localparam int IDX_W  = $clog2(MAX_COMMANDS * WORDS_PER_CMD);
   localparam int PROD_W = IDX_W + DIV6_MUL_W;

   typedef enum logic {ST_LOAD, ST_CHECK} state_type;

   typedef struct packed {
      logic              var_kind;
      logic              kbit;
      logic              in_range;
      logic              const_ok;
      logic [IDX_W-1:0]  idx;
      logic [PROD_W-1:0] prod;
   } arg_front_type;

   typedef struct packed {
      logic var_kind;
      logic kbit;
      logic in_range;
      logic const_ok;
      logic align;
      logic self_ref;
      logic ahead;
   } arg_back_type;

   function automatic arg_front_type arg_front(input logic [31:0] kind,
                                               input logic [31:0] ref_w,
                                               input logic [15:0] fc,
                                               input logic [15:0] cc,
                                               input logic [LEN_W-1:0] len);
      arg_front_type a;
      a.var_kind = (kind[31:1] == 31'd0);
      a.kbit     = kind[0];
      a.in_range = !ref_w[31] && (ref_w < 32'(len));
      a.const_ok = !ref_w[31] && (ref_w < 32'(kind[0] ? cc : fc));
      a.idx      = ref_w[IDX_W-1:0];
      a.prod     = PROD_W'(a.idx) * PROD_W'(DIV6_MUL);
      return a;
   endfunction

   function automatic logic [2:0] arg_result(input arg_back_type a, input logic [1:0] rk);
      logic [2:0] r;
      if (a.var_kind) begin
         if (!a.in_range)                r = ARG_RANGE;
         else if (!a.align)              r = ARG_ALIGN;
         else if (a.self_ref)            r = ARG_SELF;
         else if (a.ahead)               r = ARG_AHEAD;
         else if (rk != {1'b0, a.kbit})  r = ARG_TYPE;
         else                            r = ARG_OK;
      end else begin
         r = a.const_ok ? ARG_OK : ARG_CONST;
      end
      return r;
   endfunction

   cmd_type          cmd_mem [MAX_COMMANDS];
   logic [1:0]       rk_mem  [MAX_COMMANDS];

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             ovf_ff;
   logic [15:0]      fcnt_ff;
   logic [15:0]      ccnt_ff;
   logic [ADDR_W-1:0] last_ff;
   logic [LEN_W-1:0] len_ff;
   logic [ADDR_W-1:0] iss_cmd_ff;
   logic             issue_done_ff;
   logic             s1_vld_ff;
   logic             s2_vld_ff;
   logic             s3_vld_ff;
   logic             rsp_strobe_ff;
   result_type       rsp_result_ff;

   cmd_type          row_rd_ff;
   logic [1:0]       rk1_rd_ff;
   logic [1:0]       rk2_rd_ff;
   logic [ADDR_W-1:0] s1_cmd_ff;
   logic [ADDR_W-1:0] s2_cmd_ff;
   logic [ADDR_W-1:0] s3_cmd_ff;
   logic [3:0]       s2_bad_ff;
   logic [3:0]       s3_bad_ff;
   arg_front_type    s2_a1_ff;
   arg_front_type    s2_a2_ff;
   arg_back_type     s3_a1_ff;
   arg_back_type     s3_a2_ff;

   logic             accept;
   logic             full;
   logic             cfg_write;
   logic             issue_en;
   logic [1:0]       rk_code;
   logic [3:0]       s2_bad_in;
   arg_front_type    s2_a1_in;
   arg_front_type    s2_a2_in;
   logic [ADDR_W-1:0] q1;
   logic [ADDR_W-1:0] q2;
   arg_back_type     s3_a1_in;
   arg_back_type     s3_a2_in;
   logic [2:0]       a1_res;
   logic [2:0]       a2_res;
   logic [4:0]       err;
   logic             finish;

   assign busy       = (state_ff == ST_CHECK);
   assign accept     = start && !busy;
   assign full       = (cnt_ff == CNT_W'(MAX_COMMANDS));
   assign pready     = 1'b1;
   assign cfg_write  = psel && penable && pwrite && pready;
   assign prdata     = (paddr[2] == 1'(CSR_COMPLEX_COUNT)) ? {16'd0, ccnt_ff} : {16'd0, fcnt_ff};
   assign issue_en   = (state_ff == ST_CHECK) && !issue_done_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_result = rsp_result_ff;

   always_comb begin
      if (req_command.return_kind == 32'd0)      rk_code = RK_FLOAT;
      else if (req_command.return_kind == 32'd1) rk_code = RK_COMPLEX;
      else                                       rk_code = RK_OTHER;
   end

   always_comb begin
      s2_bad_in[3] = row_rd_ff.function_code[31] ||
                     (row_rd_ff.function_code >= 32'(FUNCTION_COUNT));
      s2_bad_in[2] = (row_rd_ff.return_kind > 32'd1);
      s2_bad_in[1] = (row_rd_ff.first_arg_kind > 32'd3);
      s2_bad_in[0] = (row_rd_ff.second_arg_kind > 32'd3);
      s2_a1_in = arg_front(row_rd_ff.first_arg_kind, row_rd_ff.first_arg_ref,
                           fcnt_ff, ccnt_ff, len_ff);
      s2_a2_in = arg_front(row_rd_ff.second_arg_kind, row_rd_ff.second_arg_ref,
                           fcnt_ff, ccnt_ff, len_ff);
   end

   always_comb begin
      q1 = s2_a1_ff.prod[DIV6_SHIFT +: ADDR_W];
      q2 = s2_a2_ff.prod[DIV6_SHIFT +: ADDR_W];
      s3_a1_in.var_kind = s2_a1_ff.var_kind;
      s3_a1_in.kbit     = s2_a1_ff.kbit;
      s3_a1_in.in_range = s2_a1_ff.in_range;
      s3_a1_in.const_ok = s2_a1_ff.const_ok;
      s3_a1_in.align    = (IDX_W'(q1) * IDX_W'(WORDS_PER_CMD) == s2_a1_ff.idx);
      s3_a1_in.self_ref = (q1 == s2_cmd_ff);
      s3_a1_in.ahead    = (q1 > s2_cmd_ff) && (q1 != last_ff);
      s3_a2_in.var_kind = s2_a2_ff.var_kind;
      s3_a2_in.kbit     = s2_a2_ff.kbit;
      s3_a2_in.in_range = s2_a2_ff.in_range;
      s3_a2_in.const_ok = s2_a2_ff.const_ok;
      s3_a2_in.align    = (IDX_W'(q2) * IDX_W'(WORDS_PER_CMD) == s2_a2_ff.idx);
      s3_a2_in.self_ref = (q2 == s2_cmd_ff);
      s3_a2_in.ahead    = (q2 > s2_cmd_ff) && (q2 != last_ff);
   end

   always_comb begin
      a1_res = arg_result(s3_a1_ff, rk1_rd_ff);
      a2_res = arg_result(s3_a2_ff, rk2_rd_ff);
      if (s3_bad_ff[3])          err = ERR_FUNC;
      else if (s3_bad_ff[2])     err = ERR_RET;
      else if (s3_bad_ff[1])     err = ERR_ARG1_KIND;
      else if (s3_bad_ff[0])     err = ERR_ARG2_KIND;
      else if (a1_res != ARG_OK) err = ERR_ARG1_BASE + 5'(a1_res);
      else if (a2_res != ARG_OK) err = ERR_ARG2_BASE + 5'(a2_res);
      else                       err = ERR_NONE;
      finish = s3_vld_ff && ((err != ERR_NONE) || (s3_cmd_ff == last_ff));
   end

   always_ff @(posedge clock) begin
      if (accept && !full) begin
         cmd_mem[cnt_ff[ADDR_W-1:0]] <= req_command;
         rk_mem[cnt_ff[ADDR_W-1:0]]  <= rk_code;
      end
      row_rd_ff <= cmd_mem[iss_cmd_ff];
      rk1_rd_ff <= rk_mem[q1];
      rk2_rd_ff <= rk_mem[q2];
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff <= iss_cmd_ff;
      s2_cmd_ff <= s1_cmd_ff;
      s3_cmd_ff <= s2_cmd_ff;
      s2_bad_ff <= s2_bad_in;
      s3_bad_ff <= s2_bad_ff;
      s2_a1_ff  <= s2_a1_in;
      s2_a2_ff  <= s2_a2_in;
      s3_a1_ff  <= s3_a1_in;
      s3_a2_ff  <= s3_a2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         cnt_ff        <= '0;
         ovf_ff        <= 1'b0;
         fcnt_ff       <= '0;
         ccnt_ff       <= '0;
         iss_cmd_ff    <= '0;
         issue_done_ff <= 1'b1;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         s3_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (cfg_write) begin
            if (paddr[2] == 1'(CSR_COMPLEX_COUNT)) ccnt_ff <= pwdata[15:0];
            else                                   fcnt_ff <= pwdata[15:0];
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (req_command.end_of_list) begin
                     if (ovf_ff || full) begin
                        rsp_strobe_ff                 <= 1'b1;
                        rsp_result_ff.error_code      <= ERR_OVERFLOW;
                        rsp_result_ff.failing_command <= 8'd0;
                     end else begin
                        state_ff      <= ST_CHECK;
                        iss_cmd_ff    <= '0;
                        issue_done_ff <= 1'b0;
                        last_ff       <= cnt_ff[ADDR_W-1:0];
                        len_ff        <= LEN_W'({1'b0, cnt_ff} + 1'b1) *
                                         LEN_W'(WORDS_PER_CMD);
                     end
                     cnt_ff <= '0;
                     ovf_ff <= 1'b0;
                  end else if (full) begin
                     ovf_ff <= 1'b1;
                  end else begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end
               end
            end
            ST_CHECK: begin
               if (issue_en) begin
                  iss_cmd_ff <= iss_cmd_ff + 1'b1;
                  if (iss_cmd_ff == last_ff) issue_done_ff <= 1'b1;
               end
               s1_vld_ff <= issue_en;
               s2_vld_ff <= s1_vld_ff;
               s3_vld_ff <= s2_vld_ff;
               if (finish) begin
                  state_ff                      <= ST_LOAD;
                  issue_done_ff                 <= 1'b1;
                  s1_vld_ff                     <= 1'b0;
                  s2_vld_ff                     <= 1'b0;
                  s3_vld_ff                     <= 1'b0;
                  rsp_strobe_ff                 <= 1'b1;
                  rsp_result_ff.error_code      <= err;
                  rsp_result_ff.failing_command <= (err == ERR_NONE) ? 8'd0 : 8'(s3_cmd_ff);
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) || $past(start && req_command.end_of_list)))
      else $error("Result transfer without a finished list.");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      issue_en |-> (iss_cmd_ff <= last_ff))
      else $error("Check pass reads past the last stored command.");

   a_pipe_in_check: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff || s2_vld_ff || s3_vld_ff) |-> (state_ff == ST_CHECK))
      else $error("Check pipeline active outside the check pass.");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> full)
      else $error("Overflow flagged while the store has room.");

endmodule
